>>> rtl/core/mlbt_pkg.sv
// ----------------------------------------------------------------------------
// mlbt_pkg
// Shared types and constants of the multi-channel LED blink timer.
// ----------------------------------------------------------------------------
package mlbt_pkg;

	localparam int CHANNELS_DEF = 3;
	localparam int OP_W         = 2;
	localparam int TIME_W       = 48;
	localparam int CH_W         = 2;
	localparam int MS_W         = 32;
	localparam int LED_W        = 3;
	localparam int MS_TO_US     = 1000;
	localparam int IV_W         = 42;
	localparam int S_DATA_W     = 88;
	localparam int M_DATA_W     = 8;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_FORCE = 2'd1,
		OP_BLINK = 2'd2,
		OP_MODE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_CFG,
		ST_OUT
	} state_t;

endpackage

>>> rtl/core/multi_led_blink_timer.sv
// ----------------------------------------------------------------------------
// multi_led_blink_timer
// Per-channel LED blink timers, updated one channel at a time on each tick.
// ----------------------------------------------------------------------------
// Each input item yields one output item holding the LED levels after it.
// A tick item is captured, then swept channel by channel through the
// shared 48-bit subtract-and-compare unit, then loaded into the output
// register. Force, blink and mode items take a config step instead. The
// input is not ready while an item is in work; the output register lets the
// next item start while the previous result waits. Only channels 0 to 2
// appear in led_levels; channel numbers at or above CHANNELS are ignored.
module multi_led_blink_timer #(
	parameter int CHANNELS = mlbt_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// now_us[47:0], channel[49:48], force_level[50], blink_ms[82:51],
	// repeat_mode[83], zero fill
	input  logic [mlbt_pkg::S_DATA_W-1:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [mlbt_pkg::OP_W-1:0]     s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// led_levels[2:0], zero fill
	output logic [mlbt_pkg::M_DATA_W-1:0] m_axis_tdata
);
	import mlbt_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	state_t              state_q, state_d;
	op_t                 op_q;
	logic [TIME_W-1:0]   now_q;
	logic [CH_W-1:0]     ch_q;
	logic                lvl_q;
	logic                rep_q;
	logic [TIME_W-1:0]   iv_q;
	logic [IDX_W-1:0]    idx_q;

	logic [TIME_W-1:0]   last_q [CHANNELS];
	logic [TIME_W-1:0]   ivl_q  [CHANNELS];
	logic [CHANNELS-1:0] toff_q;
	logic [CHANNELS-1:0] cont_q;
	logic [CHANNELS-1:0] phase_q;
	logic [CHANNELS-1:0] drive_q;

	logic                m_valid_q;
	logic [LED_W-1:0]    m_led_q;

	logic                accept;
	logic                idx_last;
	logic                load_out;
	logic [IDX_W-1:0]    ch_idx;
	logic                cfg_hit;
	logic [TIME_W-1:0]   elapsed;
	logic                fire;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign idx_last = (idx_q == IDX_W'(CHANNELS - 1));
	assign ch_idx   = IDX_W'(ch_q);
	assign cfg_hit  = (32'(ch_q) < 32'(CHANNELS));
	assign elapsed  = now_q - last_q[idx_q];
	assign fire     = !toff_q[idx_q] && (elapsed > ivl_q[idx_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = (op_t'(s_axis_tuser) == OP_TICK) ? ST_TICK : ST_CFG;
				end
			end
			ST_TICK: begin
				if (idx_last) begin
					state_d = ST_OUT;
				end
			end
			ST_CFG: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_axis_tuser);
			now_q <= s_axis_tdata[47:0];
			ch_q  <= s_axis_tdata[49:48];
			lvl_q <= s_axis_tdata[50];
			rep_q <= s_axis_tdata[83];
			iv_q  <= TIME_W'(IV_W'(s_axis_tdata[82:51]) * IV_W'(MS_TO_US));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= '0;
		end else if (state_q == ST_TICK && !idx_last) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_q[i] <= '0;
				ivl_q[i]  <= '0;
			end
			toff_q  <= '0;
			cont_q  <= '0;
			phase_q <= '0;
			drive_q <= '0;
		end else if (state_q == ST_TICK) begin
			if (fire) begin
				last_q[idx_q] <= now_q;
				if (cont_q[idx_q]) begin
					phase_q[idx_q] <= ~phase_q[idx_q];
					drive_q[idx_q] <= ~phase_q[idx_q];
				end else if (phase_q[idx_q]) begin
					drive_q[idx_q] <= 1'b1;
					phase_q[idx_q] <= 1'b0;
				end else begin
					drive_q[idx_q] <= 1'b0;
				end
			end
		end else if (state_q == ST_CFG && cfg_hit) begin
			case (op_q)
				OP_FORCE: begin
					drive_q[ch_idx] <= lvl_q;
					toff_q[ch_idx]  <= 1'b1;
				end
				OP_BLINK: begin
					if (toff_q[ch_idx] || ivl_q[ch_idx] != iv_q) begin
						last_q[ch_idx] <= '0;
						ivl_q[ch_idx]  <= iv_q;
						toff_q[ch_idx] <= 1'b0;
					end
					cont_q[ch_idx] <= rep_q;
					if (!rep_q) begin
						phase_q[ch_idx] <= 1'b1;
					end
				end
				OP_MODE: begin
					last_q[ch_idx] <= '0;
					cont_q[ch_idx] <= rep_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_led_q <= LED_W'(drive_q);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = M_DATA_W'(m_led_q);

	a_cfg_path: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_t'(s_axis_tuser) != OP_TICK) |=> (state_q == ST_CFG))
		else $error("config item did not enter the config step");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_OUT))
		else $error("output item appeared outside the output step");

	a_force_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CFG && op_q == OP_FORCE && cfg_hit) |=> toff_q[$past(ch_idx)])
		else $error("force item left the channel timer enabled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK) |-> !s_axis_tready)
		else $error("input ready during a channel sweep");

endmodule
